>>> sv/dlq_pkg.sv
// shared constants and command codes for the doubly linked queue manager
package dlq_pkg;

  localparam int CMD_W         = 3;
  localparam int ELEM_W        = 8;
  localparam int COUNT_W       = 9;
  localparam int POOL_SIZE_DEF = 256;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR    = 3'd0,
    CMD_ADD_HEAD = 3'd1,
    CMD_ADD_TAIL = 3'd2,
    CMD_UNLINK   = 3'd3,
    CMD_POP_HEAD = 3'd4,
    CMD_POP_TAIL = 3'd5,
    CMD_GET_NEXT = 3'd6
  } dlq_cmd_t;

endpackage

>>> sv/dlq_ifs.sv
// command and result channel interfaces of the queue manager
interface dlq_in_if;
  logic                       valid;
  logic                       ready;
  logic [dlq_pkg::CMD_W-1:0]  cmd;
  logic [dlq_pkg::ELEM_W-1:0] elem_index;

  modport source (output valid, cmd, elem_index, input ready);
  modport sink   (input valid, cmd, elem_index, output ready);
endinterface

interface dlq_out_if;
  logic                        valid;
  logic                        ready;
  logic                        status;
  logic [dlq_pkg::ELEM_W-1:0]  result_elem;
  logic                        result_valid;
  logic [dlq_pkg::ELEM_W-1:0]  head_elem;
  logic [dlq_pkg::ELEM_W-1:0]  tail_elem;
  logic [dlq_pkg::COUNT_W-1:0] count;

  modport source (output valid, status, result_elem, result_valid, head_elem, tail_elem,
                  count, input ready);
  modport sink   (input valid, status, result_elem, result_valid, head_elem, tail_elem,
                  count, output ready);
endinterface

>>> sv/dlq_link_ram.sv
// link table: one write port, one read port, registered read data
module dlq_link_ram #(
  parameter  int DEPTH  = dlq_pkg::POOL_SIZE_DEF,
  parameter  int DATA_W = $clog2(DEPTH + 1),
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/dlq_ctrl.sv
// command sequencer: link reads, neighbor updates, head/tail/count and result register
module dlq_ctrl #(
  parameter  int POOL_SIZE = dlq_pkg::POOL_SIZE_DEF,
  localparam int SLOT_W    = $clog2(POOL_SIZE),
  localparam int LINK_W    = $clog2(POOL_SIZE + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  dlq_in_if.sink            in_chan,
  dlq_out_if.source         out_chan,
  output logic              rd_en,
  output logic [SLOT_W-1:0] rd_addr,
  input  logic [LINK_W-1:0] n_rdata,
  input  logic [LINK_W-1:0] p_rdata,
  output logic              n_we,
  output logic [SLOT_W-1:0] n_waddr,
  output logic [LINK_W-1:0] n_wdata,
  output logic              p_we,
  output logic [SLOT_W-1:0] p_waddr,
  output logic [LINK_W-1:0] p_wdata
);

  localparam int ELEM_W  = dlq_pkg::ELEM_W;
  localparam int COUNT_W = dlq_pkg::COUNT_W;
  localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(POOL_SIZE);

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_CLEAN, S_HOLD} state_t;

  state_t              state_r;
  dlq_pkg::dlq_cmd_t   cmd_r;
  dlq_pkg::dlq_cmd_t   in_cmd;
  logic [SLOT_W-1:0]   e_r;
  logic                in_pool_r;
  logic [SLOT_W-1:0]   head_r, tail_r;
  logic [LINK_W-1:0]   cnt_r;
  logic                status_r, res_valid_r;
  logic [SLOT_W-1:0]   res_r;
  logic                clr_n_r, clr_p_r;

  logic                out_valid_r, out_status_r, out_res_valid_r;
  logic [ELEM_W-1:0]   out_res_r, out_head_r, out_tail_r;
  logic [COUNT_W-1:0]  out_count_r;

  // decisions made in the look step
  logic [SLOT_W-1:0]   head_nxt, tail_nxt, res_nxt;
  logic [LINK_W-1:0]   cnt_nxt;
  logic                status_nxt, res_valid_nxt, clr_n_nxt, clr_p_nxt;
  logic                lk_n_we, lk_p_we;
  logic [SLOT_W-1:0]   lk_n_addr, lk_p_addr;
  logic [LINK_W-1:0]   lk_n_data, lk_p_data;
  logic                is_empty, nq_slot, pq_slot, in_acc, out_free;
  logic                out_load;

  assign in_cmd   = dlq_pkg::dlq_cmd_t'(in_chan.cmd);
  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc   = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;
  assign out_load = ((state_r == S_CLEAN) || (state_r == S_HOLD)) && out_free;

  // pops read the links of the current end slot
  always_comb begin
    priority if (in_cmd == dlq_pkg::CMD_POP_HEAD) begin
      rd_addr = head_r;
    end else if (in_cmd == dlq_pkg::CMD_POP_TAIL) begin
      rd_addr = tail_r;
    end else begin
      rd_addr = SLOT_W'(in_chan.elem_index);
    end
  end
  assign rd_en = in_acc;

  assign is_empty = (cnt_r == '0);
  assign nq_slot  = (n_rdata < LINK_NONE);
  assign pq_slot  = (p_rdata < LINK_NONE);

  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cnt_nxt       = cnt_r;
    status_nxt    = 1'b0;
    res_nxt       = '0;
    res_valid_nxt = 1'b0;
    clr_n_nxt     = 1'b0;
    clr_p_nxt     = 1'b0;
    lk_n_we       = 1'b0;
    lk_p_we       = 1'b0;
    lk_n_addr     = e_r;
    lk_p_addr     = e_r;
    lk_n_data     = LINK_NONE;
    lk_p_data     = LINK_NONE;
    unique case (cmd_r)
      dlq_pkg::CMD_CLEAR: begin
        head_nxt = '0;
        tail_nxt = '0;
        cnt_nxt  = '0;
      end
      dlq_pkg::CMD_ADD_HEAD, dlq_pkg::CMD_ADD_TAIL: begin
        if (in_pool_r) begin
          if (is_empty) begin
            lk_n_we  = 1'b1;
            lk_p_we  = 1'b1;
            head_nxt = e_r;
            tail_nxt = e_r;
          end else if (cmd_r == dlq_pkg::CMD_ADD_HEAD) begin
            lk_p_we   = 1'b1;
            lk_p_addr = head_r;
            lk_p_data = LINK_W'(e_r);
            lk_n_we   = 1'b1;
            lk_n_data = LINK_W'(head_r);
            clr_p_nxt = 1'b1;
            head_nxt  = e_r;
          end else begin
            lk_n_we   = 1'b1;
            lk_n_addr = tail_r;
            lk_n_data = LINK_W'(e_r);
            lk_p_we   = 1'b1;
            lk_p_data = LINK_W'(tail_r);
            clr_n_nxt = 1'b1;
            tail_nxt  = e_r;
          end
          if (cnt_r < LINK_NONE) begin
            cnt_nxt = cnt_r + LINK_W'(1);
          end
        end
      end
      dlq_pkg::CMD_UNLINK, dlq_pkg::CMD_POP_HEAD, dlq_pkg::CMD_POP_TAIL: begin
        if (is_empty) begin
          status_nxt = 1'b1;
        end else if (in_pool_r) begin
          if (cmd_r != dlq_pkg::CMD_UNLINK) begin
            res_nxt       = e_r;
            res_valid_nxt = 1'b1;
          end
          // neighbors first, the slot's own links are cleared in the next step
          priority if (cnt_r == LINK_W'(1)) begin
            head_nxt = '0;
            tail_nxt = '0;
          end else if (head_r == e_r) begin
            if (nq_slot) begin
              lk_p_we   = 1'b1;
              lk_p_addr = SLOT_W'(n_rdata);
              head_nxt  = SLOT_W'(n_rdata);
            end else begin
              head_nxt = '0;
            end
          end else if (tail_r == e_r) begin
            if (pq_slot) begin
              lk_n_we   = 1'b1;
              lk_n_addr = SLOT_W'(p_rdata);
              tail_nxt  = SLOT_W'(p_rdata);
            end else begin
              tail_nxt = '0;
            end
          end else begin
            lk_n_we   = pq_slot;
            lk_n_addr = SLOT_W'(p_rdata);
            lk_n_data = n_rdata;
            lk_p_we   = nq_slot;
            lk_p_addr = SLOT_W'(n_rdata);
            lk_p_data = p_rdata;
          end
          clr_n_nxt = 1'b1;
          clr_p_nxt = 1'b1;
          cnt_nxt   = cnt_r - LINK_W'(1);
        end
      end
      dlq_pkg::CMD_GET_NEXT: begin
        if (is_empty) begin
          status_nxt = 1'b1;
        end else if (in_pool_r && nq_slot) begin
          res_nxt       = SLOT_W'(n_rdata);
          res_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (state_r == S_LOOK) begin
      n_we    = lk_n_we;
      n_waddr = lk_n_addr;
      n_wdata = lk_n_data;
      p_we    = lk_p_we;
      p_waddr = lk_p_addr;
      p_wdata = lk_p_data;
    end else begin
      n_we    = (state_r == S_CLEAN) && clr_n_r;
      n_waddr = e_r;
      n_wdata = LINK_NONE;
      p_we    = (state_r == S_CLEAN) && clr_p_r;
      p_waddr = e_r;
      p_wdata = LINK_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            cmd_r     <= in_cmd;
            e_r       <= rd_addr;
            in_pool_r <= (in_cmd == dlq_pkg::CMD_POP_HEAD) ||
                         (in_cmd == dlq_pkg::CMD_POP_TAIL) ||
                         (32'(in_chan.elem_index) < POOL_SIZE);
            state_r   <= S_LOOK;
          end
        end
        S_LOOK: begin
          head_r      <= head_nxt;
          tail_r      <= tail_nxt;
          cnt_r       <= cnt_nxt;
          status_r    <= status_nxt;
          res_r       <= res_nxt;
          res_valid_r <= res_valid_nxt;
          clr_n_r     <= clr_n_nxt;
          clr_p_r     <= clr_p_nxt;
          state_r     <= S_CLEAN;
        end
        S_CLEAN, S_HOLD: begin
          if (out_free) begin
            out_status_r    <= status_r;
            out_res_r       <= ELEM_W'(res_r);
            out_res_valid_r <= res_valid_r;
            out_head_r      <= is_empty ? '0 : ELEM_W'(head_r);
            out_tail_r      <= is_empty ? '0 : ELEM_W'(tail_r);
            out_count_r     <= COUNT_W'(cnt_r);
            state_r         <= S_IDLE;
          end else begin
            state_r <= S_HOLD;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = out_status_r;
  assign out_chan.result_elem  = out_res_r;
  assign out_chan.result_valid = out_res_valid_r;
  assign out_chan.head_elem    = out_head_r;
  assign out_chan.tail_elem    = out_tail_r;
  assign out_chan.count        = out_count_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LINK_NONE)
    else $error("element count beyond pool size");

  a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
    (n_we || p_we) |-> (state_r == S_LOOK || state_r == S_CLEAN))
    else $error("link write outside the update steps");

  a_accept_look: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_LOOK))
    else $error("accepted item did not move to the look step");

  a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOK && cmd_r == dlq_pkg::CMD_CLEAR) |=> (cnt_r == '0))
    else $error("clear left a nonzero count");

  a_empty_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r) |-> !out_res_valid_r)
    else $error("empty status together with a result element");
`endif

endmodule

>>> sv/doubly_linked_queue_manager.sv
// Doubly linked queue manager over a pool of element slots.
//
// in_chan carries one command item (cmd, elem_index): clear, add at head, add at
// tail, unlink a slot, pop head, pop tail or read the successor of a slot.
// out_chan returns exactly one result item per command: status, result_elem,
// result_valid and the head, tail and count after the command.
// Both channels use valid/ready; an item moves when both are high.
// The result is loaded into the output register after the look and clean steps,
// once that register is free.
// Each command is worked in steps set by the link tables: read a slot's next and
// previous links, write the neighbors' links, then clear the slot's own links
// (one write port each); the next command is taken once these steps are done.
// The result sits in an output register; while it waits for out_chan.ready the
// next command is still accepted and worked, holding in its last step until
// the output register frees up.
// Reset (synchronous, active low) empties the queue: head, tail and count go to
// zero. The link tables are not cleared and need no sweep; a slot's links are
// written whenever it is inserted.
module doubly_linked_queue_manager #(
  parameter int POOL_SIZE = dlq_pkg::POOL_SIZE_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  dlq_in_if.sink    in_chan,
  dlq_out_if.source out_chan
);

  localparam int SLOT_W = $clog2(POOL_SIZE);
  localparam int LINK_W = $clog2(POOL_SIZE + 1);

  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr;
  logic [LINK_W-1:0] n_rdata, p_rdata;
  logic              n_we, p_we;
  logic [SLOT_W-1:0] n_waddr, p_waddr;
  logic [LINK_W-1:0] n_wdata, p_wdata;

  dlq_ctrl #(
    .POOL_SIZE (POOL_SIZE)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .n_rdata  (n_rdata),
    .p_rdata  (p_rdata),
    .n_we     (n_we),
    .n_waddr  (n_waddr),
    .n_wdata  (n_wdata),
    .p_we     (p_we),
    .p_waddr  (p_waddr),
    .p_wdata  (p_wdata)
  );

  // successor links
  dlq_link_ram #(
    .DEPTH  (POOL_SIZE),
    .DATA_W (LINK_W)
  ) u_next_ram (
    .clk   (clk),
    .we    (n_we),
    .waddr (n_waddr),
    .wdata (n_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (n_rdata)
  );

  // predecessor links
  dlq_link_ram #(
    .DEPTH  (POOL_SIZE),
    .DATA_W (LINK_W)
  ) u_prev_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (p_rdata)
  );

endmodule
